// File: rtl/sbt_pkg.sv
// Shared types and constants for the sorted breakpoint table.
// Used by the channel interfaces, the cell, the controller and the top level.
package sbt_pkg;

  localparam int TABLE_DEPTH = 1024;
  // Internal widths follow the depth; port widths are fixed.
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ADDR_W      = 32;
  localparam int FUNC_W      = 2;
  localparam int POS_OUT_W   = 10;
  localparam int COUNT_OUT_W = 11;

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic rot;   // rotate left within the occupied ring
    logic ins;   // shift right, cell 0 takes the key
    logic del;   // shift left, dropping cell 0
  } cell_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SEARCH  = 5'b00010,
    ST_RESTORE = 5'b00100,
    ST_DONE    = 5'b01000,
    ST_SPARE   = 5'b10000
  } state_t;

endpackage

// File: rtl/sbt_if.sv
// Request and response channel interfaces (valid/ready).
// Depends on sbt_pkg for field widths.
interface sbt_req_if import sbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output func, output address, input ready);
  modport sink   (input valid, input func, input address, output ready);
endinterface

interface sbt_rsp_if import sbt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   success;
  logic [POS_OUT_W-1:0]   position;
  logic [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, output success, output position, output entry_count,
                  input ready);
  modport sink   (input valid, input success, input position, input entry_count,
                  output ready);
endinterface

// File: rtl/sorted_breakpoint_table.sv
// Sorted breakpoint table: a ring of address cells kept in ascending order.
// Channels: req (func, address) in, rsp (success, position, entry_count) out,
// both valid/ready; a transaction completes when valid and ready are high
// at a rising edge of clk.
// One request is processed at a time. The stored addresses rotate through
// cell 0, one place per cycle, past a single comparator: the search rotates
// past each entry below the key, and the ring then rotates on until the
// smallest entry is back in cell 0. No rotation is needed when the key is
// at or below the smallest entry, for a full-table add or for an unused
// func code. The next request can be accepted in the cycle after the
// response is loaded.
// req.ready is high only while no request is in progress.
// The response sits in an output register; a finished request waits there
// while the receiver stalls, and the next request can already be accepted.
// If rsp.ready stays low, a second finished request holds inside until the
// register frees.
// rst (synchronous, active high) empties the table; no clearing pass is
// needed, since cells at or beyond the count are never compared.
// Depends on sbt_pkg, sbt_if, sbt_cell and sbt_ctrl.
module sorted_breakpoint_table import sbt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sbt_req_if.sink   req,
  sbt_rsp_if.source rsp
);

  cell_ctl_t         ctl;
  logic [ADDR_W-1:0] key;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] val [TABLE_DEPTH];

  sbt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .head  (val[0]),
    .ctl   (ctl),
    .key   (key),
    .count (count)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [ADDR_W-1:0] left_val;
    logic [ADDR_W-1:0] right_val;
    logic              last;

    if (i == 0) begin : g_first
      assign left_val = key;
    end else begin : g_mid
      assign left_val = val[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_end
      assign right_val = val[0];
    end else begin : g_inner
      assign right_val = val[i+1];
    end
    assign last = (count == CNT_W'(i + 1));

    sbt_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .last      (last),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (val[0]),
      .val       (val[i])
    );
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.rot, ctl.ins, ctl.del}))
    else $error("conflicting cell commands");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count)) || (count == $past(count) + 1'b1) ||
                    (count + 1'b1 == $past(count)))
    else $error("entry count moved by more than one");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while another is in progress");

  a_no_shift_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !ctl.ins && !ctl.del && !ctl.rot)
    else $error("cells changed while idle");

endmodule

// File: rtl/sbt_cell.sv
// One storage cell of the breakpoint ring: holds a single address.
// Depends on sbt_pkg for the command struct.
module sbt_cell import sbt_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic              last,
  input  logic [ADDR_W-1:0] left_val,
  input  logic [ADDR_W-1:0] right_val,
  input  logic [ADDR_W-1:0] head_val,
  output logic [ADDR_W-1:0] val
);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      val <= left_val;
    end else if (ctl.del) begin
      val <= right_val;
    end else if (ctl.rot) begin
      // last occupied cell closes the ring
      val <= last ? head_val : right_val;
    end
  end

endmodule

// File: rtl/sbt_ctrl.sv
// Sequencer for the breakpoint ring: search, insert/delete, restore order.
// Depends on sbt_pkg and the channel interfaces; drives all cells.
module sbt_ctrl import sbt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  sbt_req_if.sink           req,
  sbt_rsp_if.source         rsp,
  input  logic [ADDR_W-1:0] head,
  output cell_ctl_t         ctl,
  output logic [ADDR_W-1:0] key,
  output logic [CNT_W-1:0]  count
);

  state_t             state, state_next;
  logic [FUNC_W-1:0]  func_q;
  logic [CNT_W-1:0]   off, off_next;
  logic [CNT_W-1:0]   count_next;
  logic               success_q, success_next;
  logic [IDX_W-1:0]   pos_q, pos_next;
  logic               full, in_ring, found, rsp_load;

  assign req.ready = (state == ST_IDLE);
  assign full      = (count == CNT_W'(TABLE_DEPTH));
  assign in_ring   = (off < count);
  assign found     = in_ring && (head == key);
  assign rsp_load  = (state == ST_DONE) && (!rsp.valid || rsp.ready);

  always_comb begin
    state_next   = state;
    off_next     = off;
    count_next   = count;
    success_next = success_q;
    pos_next     = pos_q;
    ctl          = '0;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next   = ST_SEARCH;
          off_next     = '0;
          success_next = 1'b0;
          pos_next     = '0;
        end
      end
      ST_SEARCH: begin
        if (!(func_q inside {FUNC_LOOKUP, FUNC_ADD, FUNC_REMOVE}) ||
            (func_q == FUNC_ADD && full)) begin
          state_next = ST_RESTORE;
        end else if (in_ring && head < key) begin
          ctl.rot  = 1'b1;
          off_next = off + 1'b1;
        end else begin
          // head is the first entry not below the key, or the ring is exhausted
          state_next = ST_RESTORE;
          case (func_q)
            FUNC_LOOKUP: begin
              success_next = found;
              pos_next     = found ? off[IDX_W-1:0] : '0;
            end
            FUNC_ADD: begin
              success_next = 1'b1;
              if (!found) begin
                ctl.ins    = 1'b1;
                count_next = count + 1'b1;
              end
            end
            default: begin
              success_next = found;
              if (found) begin
                ctl.del    = 1'b1;
                count_next = count - 1'b1;
              end
            end
          endcase
        end
      end
      ST_RESTORE: begin
        // keep rotating until the smallest entry is back in cell 0
        if (off == '0 || off == count) begin
          state_next = ST_DONE;
        end else begin
          ctl.rot  = 1'b1;
          off_next = off + 1'b1;
        end
      end
      ST_DONE: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    off       <= off_next;
    success_q <= success_next;
    pos_q     <= pos_next;
    if (req.valid && req.ready) begin
      func_q <= req.func;
      key    <= req.address;
    end
    if (rsp_load) begin
      rsp.success     <= success_q;
      rsp.position    <= POS_OUT_W'(pos_q);
      rsp.entry_count <= COUNT_OUT_W'(count);
    end
  end

endmodule
